// File: rtl/core/cpn_pkg.sv
// Widths and constants for the normalized cross-power spectrum pipeline.
package cpn_pkg;

  localparam int IN_W   = 24;
  localparam int OUT_W  = 16;
  localparam int PROD_W = 2 * IN_W;       // one 24x24 product
  localparam int SUM_W  = PROD_W + 1;     // a or b with sign
  localparam int MAG_W  = PROD_W;         // |a|, |b|
  localparam int SH_W   = 6;              // shift amount 0..32
  localparam int NRM_W  = 16;             // shifted magnitude
  localparam int SQ_W   = 2 * NRM_W + 1;  // A^2 + B^2
  localparam int LIM_W  = 2 * NRM_W + 30; // A^2 * 2^30
  localparam int QB     = 15;             // quotient bits searched
  localparam int QS_W   = QB + SQ_W;      // q * S
  localparam int Q2S_W  = 64;             // q^2 * S
  localparam int CMP_W  = 68;             // test value with headroom
  localparam logic [QB-1:0] ONE_Q14 = 15'd16384;

  typedef logic [QB-1:0] quo_t;

endpackage

// File: rtl/core/cross_power_normalize.sv
// Normalized cross-power spectrum bin: F*conj(M)/|F*conj(M)| in Q1.14.
// Pipeline: 6 front stages, 15 quotient stages, one output register.
// Throughput: one bin per cycle; the whole pipeline advances whenever the output
//   register is empty or its beat is taken.
// Reset: rst_n synchronous, active low, clears the valid bits only.
module cross_power_normalize (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [cpn_pkg::IN_W-1:0]  in_fix_re,
  input  logic signed [cpn_pkg::IN_W-1:0]  in_fix_im,
  input  logic signed [cpn_pkg::IN_W-1:0]  in_mov_re,
  input  logic signed [cpn_pkg::IN_W-1:0]  in_mov_im,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [cpn_pkg::OUT_W-1:0] out_re,
  output logic signed [cpn_pkg::OUT_W-1:0] out_im
);
  import cpn_pkg::*;

  localparam int NST = 6 + QB + 1;

  logic [NST-1:0] vld_r;
  logic           en;

  // stage 1: products
  logic signed [PROD_W-1:0] p_rr_r, p_ii_r, p_ir_r, p_ri_r;
  // stage 2: a, b
  logic signed [SUM_W-1:0]  a_r, b_r;
  // stage 3: magnitudes and shift
  logic [MAG_W-1:0] ua_r, ub_r;
  logic [SH_W-1:0]  sh_nxt;
  // sign / zero flags travel along; index = stage number
  logic [NST-1:3] nega_r, negb_r, zero_r;
  // stage 4: shifted
  logic [NRM_W-1:0] sa_r, sb_r;
  // stage 5: squares
  logic [2*NRM_W-1:0] sqa_r, sqb_r;
  // stage 6 onward: search state, index 0 is stage 6
  logic [SQ_W-1:0]  s2_r  [QB+1];
  logic [LIM_W-1:0] lim_r [QB+1][2];
  quo_t             q_r   [QB+1][2];
  logic [QS_W-1:0]  qs_r  [QB+1][2];
  logic [Q2S_W-1:0] q2s_r [QB+1][2];

  quo_t             q_nxt   [QB][2];
  logic [QS_W-1:0]  qs_nxt  [QB][2];
  logic [Q2S_W-1:0] q2s_nxt [QB][2];

  logic [OUT_W-1:0] ore_r, oim_r;
  logic [MAG_W-1:0] mx;

  assign en       = ~vld_r[NST-1] | out_ready;
  assign in_ready = en;
  assign out_valid = vld_r[NST-1];
  assign out_re = ore_r;
  assign out_im = oim_r;

  // shift: smallest s with (|a|||b|) >> s below 2^16
  assign mx = ua_r | ub_r;
  always_comb begin
    sh_nxt = '0;
    for (int i = NRM_W; i < MAG_W; i++) begin
      if (mx[i]) sh_nxt = SH_W'(i - NRM_W + 1);
    end
  end

  // quotient bit search: test (2c-1)^2*S <= m^2*2^30 with c = q + 2^k,
  // using running q*S and q^2*S so only shifts and adds are needed
  always_comb begin
    for (int j = 0; j < QB; j++) begin
      for (int l = 0; l < 2; l++) begin
        logic [CMP_W-1:0] t, s_w, qs_w;
        logic             ok;
        s_w  = CMP_W'(s2_r[j]);
        qs_w = CMP_W'(qs_r[j][l]);
        t = (CMP_W'(q2s_r[j][l]) << 2) + (qs_w << (QB - j + 2)) - (qs_w << 2)
            + (s_w << (2 * (QB - 1 - j) + 2)) - (s_w << (QB - j + 1)) + s_w;
        // once q reaches one, no candidate stays within range
        ok = (t <= CMP_W'(lim_r[j][l])) && (q_r[j][l] != ONE_Q14);
        q_nxt[j][l]   = q_r[j][l];
        qs_nxt[j][l]  = qs_r[j][l];
        q2s_nxt[j][l] = q2s_r[j][l];
        if (ok) begin
          q_nxt[j][l]   = q_r[j][l] | (quo_t'(1) << (QB - 1 - j));
          qs_nxt[j][l]  = QS_W'(qs_w + (s_w << (QB - 1 - j)));
          q2s_nxt[j][l] = Q2S_W'(CMP_W'(q2s_r[j][l]) + (qs_w << (QB - j))
                                 + (s_w << (2 * (QB - 1 - j))));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_rr_r <= PROD_W'(in_fix_re * in_mov_re);
      p_ii_r <= PROD_W'(in_fix_im * in_mov_im);
      p_ir_r <= PROD_W'(in_fix_im * in_mov_re);
      p_ri_r <= PROD_W'(in_fix_re * in_mov_im);

      a_r <= SUM_W'(p_rr_r) + SUM_W'(p_ii_r);
      b_r <= SUM_W'(p_ir_r) - SUM_W'(p_ri_r);

      ua_r <= a_r[SUM_W-1] ? MAG_W'(-a_r) : MAG_W'(a_r);
      ub_r <= b_r[SUM_W-1] ? MAG_W'(-b_r) : MAG_W'(b_r);
      nega_r[3] <= a_r[SUM_W-1];
      negb_r[3] <= b_r[SUM_W-1];
      zero_r[3] <= (a_r == '0) && (b_r == '0);

      sa_r <= NRM_W'(ua_r >> sh_nxt);
      sb_r <= NRM_W'(ub_r >> sh_nxt);

      sqa_r <= sa_r * sa_r;
      sqb_r <= sb_r * sb_r;

      s2_r[0]     <= SQ_W'(sqa_r) + SQ_W'(sqb_r);
      lim_r[0][0] <= LIM_W'(sqa_r) << 30;
      lim_r[0][1] <= LIM_W'(sqb_r) << 30;
      for (int l = 0; l < 2; l++) begin
        q_r[0][l]   <= '0;
        qs_r[0][l]  <= '0;
        q2s_r[0][l] <= '0;
      end

      for (int j = 0; j < QB; j++) begin
        s2_r[j+1] <= s2_r[j];
        for (int l = 0; l < 2; l++) begin
          lim_r[j+1][l] <= lim_r[j][l];
          q_r[j+1][l]   <= q_nxt[j][l];
          qs_r[j+1][l]  <= qs_nxt[j][l];
          q2s_r[j+1][l] <= q2s_nxt[j][l];
        end
      end

      for (int i = 4; i < NST; i++) begin
        nega_r[i] <= nega_r[i-1];
        negb_r[i] <= negb_r[i-1];
        zero_r[i] <= zero_r[i-1];
      end

      if (zero_r[NST-1]) begin
        ore_r <= '0;
        oim_r <= '0;
      end else begin
        ore_r <= nega_r[NST-1] ? -OUT_W'(q_r[QB][0]) : OUT_W'(q_r[QB][0]);
        oim_r <= negb_r[NST-1] ? -OUT_W'(q_r[QB][1]) : OUT_W'(q_r[QB][1]);
      end
    end
  end

endmodule

// File: tb/sv/tb_top.sv
// Testbench for cross_power_normalize: directed table plus random bins vs. a local predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cpn_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [IN_W-1:0] in_fix_re = '0, in_fix_im = '0, in_mov_re = '0, in_mov_im = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_W-1:0] out_re, out_im;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  cross_power_normalize i_dut (.*);

  typedef struct {
    logic signed [OUT_W-1:0] re;
    logic signed [OUT_W-1:0] im;
  } phasor_t;

  typedef struct {
    logic signed [IN_W-1:0] fr, fi, mr, mi;
    logic                   known;
    logic signed [OUT_W-1:0] re, im;
  } bin_row_t;

  phasor_t expected_q[$];
  int errors = 0;
  int in_idle_pct = 17;
  int out_idle_pct = 70;
  longint unsigned cycle_cnt = 0;
  localparam longint unsigned CYCLE_LIMIT = 400000;
  localparam int LATENCY = 22;

  // Largest q <= 16384 with (2q-1)^2 * s2 <= m^2 * 2^30, via bit search.
  function automatic logic [15:0] unit_code(logic [63:0] m, logic [63:0] s2);
    logic [127:0] lim, t;
    logic [15:0]  q, c;
    lim = ({64'd0, m} * m) << 30;
    q = '0;
    for (int bit_i = 14; bit_i >= 0; bit_i--) begin
      c = q | (16'd1 << bit_i);
      if (c <= 16'd16384) begin
        t = 128'(2 * c - 1);
        if (t * t * s2 <= lim) q = c;
      end
    end
    return q;
  endfunction

  function automatic phasor_t predict_phasor(logic signed [IN_W-1:0] fr, fi, mr, mi);
    phasor_t r;
    logic signed [63:0] a, b;
    logic [63:0] ua, ub, mx, sa, sb, s2;
    logic [15:0] qa, qb;
    int sh;
    a = 64'(fr) * 64'(mr) + 64'(fi) * 64'(mi);
    b = 64'(fi) * 64'(mr) - 64'(fr) * 64'(mi);
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    mx = ua | ub;
    r.re = '0;
    r.im = '0;
    if (mx != 0) begin
      sh = 0;
      while ((mx >> sh) >= 64'd65536) sh++;
      sa = ua >> sh;
      sb = ub >> sh;
      s2 = sa * sa + sb * sb;
      qa = unit_code(sa, s2);
      qb = unit_code(sb, s2);
      r.re = a < 0 ? -qa : qa;
      r.im = b < 0 ? -qb : qb;
    end
    return r;
  endfunction

  localparam logic signed [IN_W-1:0] PMAX = 24'sh7FFFFF;
  localparam logic signed [IN_W-1:0] NMAX = 24'sh800000;

  bin_row_t bin_table[] = '{
    '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b1, 16'sd0, 16'sd0},
    '{24'sd5, 24'sd7, 24'sd0, 24'sd0, 1'b1, 16'sd0, 16'sd0},
    '{24'sd0, 24'sd0, NMAX, PMAX, 1'b1, 16'sd0, 16'sd0},
    '{24'sd1, 24'sd0, 24'sd1, 24'sd0, 1'b1, 16'sd16384, 16'sd0},
    '{24'sd0, 24'sd1, 24'sd1, 24'sd0, 1'b1, 16'sd0, 16'sd16384},
    '{24'sd1, 24'sd0, -24'sd1, 24'sd0, 1'b1, -16'sd16384, 16'sd0},
    '{24'sd0, -24'sd1, 24'sd1, 24'sd0, 1'b1, 16'sd0, -16'sd16384},
    '{PMAX, 24'sd0, PMAX, 24'sd0, 1'b1, 16'sd16384, 16'sd0},
    '{NMAX, 24'sd0, NMAX, 24'sd0, 1'b1, 16'sd16384, 16'sd0},
    '{NMAX, NMAX, NMAX, NMAX, 1'b0, 16'sd0, 16'sd0},
    '{PMAX, NMAX, NMAX, PMAX, 1'b0, 16'sd0, 16'sd0},
    '{NMAX, PMAX, PMAX, PMAX, 1'b0, 16'sd0, 16'sd0},
    '{PMAX, PMAX, PMAX, NMAX, 1'b0, 16'sd0, 16'sd0},
    '{24'sd1, 24'sd1, 24'sd1, 24'sd0, 1'b0, 16'sd0, 16'sd0},
    '{24'sd3, 24'sd4, 24'sd1, 24'sd0, 1'b0, 16'sd0, 16'sd0},
    '{-24'sd3, 24'sd4, 24'sd0, -24'sd1, 1'b0, 16'sd0, 16'sd0},
    '{24'sd65535, 24'sd1, 24'sd1, 24'sd0, 1'b0, 16'sd0, 16'sd0},
    '{24'sd65536, 24'sd1, 24'sd1, 24'sd0, 1'b0, 16'sd0, 16'sd0},
    '{24'sd1000, 24'sd1, 24'sd1, 24'sd0, 1'b0, 16'sd0, 16'sd0},
    '{24'sh555555, 24'shAAAAAA, 24'sh2AAAAA, 24'shD55555, 1'b0, 16'sd0, 16'sd0}
  };

  function automatic logic signed [IN_W-1:0] rand_part();
    case ($urandom_range(0, 5))
      0: return IN_W'($urandom);
      1: return IN_W'($signed($urandom_range(0, 64)) - 32);
      2: return IN_W'($signed($urandom_range(0, 8191)) - 4096);
      3: return $urandom_range(0, 1) ? PMAX : NMAX;
      4: return '0;
      default: return IN_W'($signed($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  // valid drops only while idling, so each edge sees at most one update of it
  task automatic send_bin(logic signed [IN_W-1:0] fr, fi, mr, mi);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_fix_re <= fr;
    in_fix_im <= fi;
    in_mov_re <= mr;
    in_mov_im <= mi;
    expected_q = {expected_q, predict_phasor(fr, fi, mr, mi)};
    do @(posedge clk); while (!in_ready);
  endtask

  // receiver: random stall, checks each accepted beat
  always @(posedge clk) begin
    phasor_t exp_p;
    if (rst_n) begin
      out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result beat re=%0d im=%0d", out_re, out_im);
          errors++;
        end else begin
          exp_p = expected_q.pop_front();
          if (out_re !== exp_p.re) begin
            $error("out_re expected %0d actual %0d", exp_p.re, out_re);
            errors++;
          end
          if (out_im !== exp_p.im) begin
            $error("out_im expected %0d actual %0d", exp_p.im, out_im);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    phasor_t p;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (bin_table[i]) begin
      if (bin_table[i].known) begin
        p = predict_phasor(bin_table[i].fr, bin_table[i].fi, bin_table[i].mr, bin_table[i].mi);
        if (p.re !== bin_table[i].re || p.im !== bin_table[i].im) begin
          $error("table row %0d: predictor disagrees with typed result", i);
          errors++;
        end
      end
      send_bin(bin_table[i].fr, bin_table[i].fi, bin_table[i].mr, bin_table[i].mi);
    end
    for (int phase = 0; phase < 3; phase++) begin
      in_idle_pct  = (phase == 0) ? 17 : (phase == 1) ? 70 : 0;
      out_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 17 : 0;
      repeat (550) send_bin(rand_part(), rand_part(), rand_part(), rand_part());
    end
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

// File: sim.f
rtl/core/cpn_pkg.sv
rtl/core/cross_power_normalize.sv
tb/sv/tb_top.sv
